// ===== src/i2c_eeprom_transaction_sequencer_defines.svh =====
// Assertion macros shared by the I2C EEPROM sequencer RTL.
// Depends on nothing; the asserting scope must provide clk and rst_n.
`ifndef I2C_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define IETS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define IETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/iets_pkg.sv =====
// Shared types and codes for the I2C EEPROM transaction sequencer.
// Depends on nothing; imported by every module of the block.
package iets_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // Opcodes of an input word
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Bus actions of a result word
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_RCV_EN  = 3'd4;
  localparam logic [2:0] ACT_ACK     = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        write_mode;
    logic [15:0] cell_address;
    logic [4:0]  transfer_length;
    logic [3:0]  byte_index;
    logic [7:0]  byte_value;
    logic        bus_event;
    logic        ack_status;
    logic        receive_full;
    logic [7:0]  receive_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       accepted;
    logic       idle;
    logic       success;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

// ===== src/iets_buf.sv =====
// Write data buffer: one write port, one registered read port.
// Depends on iets_pkg for depth and the write request type.
module iets_buf (
  input  logic                    clk,
  input  iets_pkg::buf_wr_t       wr,
  input  logic [iets_pkg::BUF_AW-1:0] rd_addr,
  output logic [7:0]              rd_data
);
  import iets_pkg::*;

  logic [7:0] buf_mem_r [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      buf_mem_r[wr.addr] <= wr.data;
    end
  end

  // forward a same-cycle write to the read port
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= buf_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/iets_ctrl.sv =====
// Transfer step logic and configuration registers of the sequencer.
// Depends on iets_pkg, the assertion macro header and the buffer read data from iets_buf.
`include "i2c_eeprom_transaction_sequencer_defines.svh"
module iets_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        item_acc,
  input  iets_pkg::item_t             item,
  input  logic [7:0]                  rd_data,
  output logic [iets_pkg::BUF_AW-1:0] rd_addr,
  output iets_pkg::buf_wr_t           wr,
  output iets_pkg::res_t              res
);
  import iets_pkg::*;

  localparam logic [3:0] ST_READY     = 4'd0;
  localparam logic [3:0] ST_START     = 4'd1;
  localparam logic [3:0] ST_DEV       = 4'd2;
  localparam logic [3:0] ST_CELL_HI   = 4'd3;
  localparam logic [3:0] ST_CELL_LO   = 4'd4;
  localparam logic [3:0] ST_DATA      = 4'd5;
  localparam logic [3:0] ST_STOP      = 4'd6;
  localparam logic [3:0] ST_WAIT_BIT  = 4'd7;
  localparam logic [3:0] ST_WAIT_BYTE = 4'd8;
  localparam logic [3:0] ST_RESTART   = 4'd9;
  localparam logic [3:0] ST_DEV_READ  = 4'd10;
  localparam logic [3:0] ST_RCV_EN    = 4'd11;
  localparam logic [3:0] ST_IN_DATA   = 4'd12;

  logic [3:0]  step_r, step_nxt;
  logic [3:0]  ret_r, ret_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  len_r, len_nxt;
  logic        mode_r, mode_nxt;
  logic [15:0] cell_r, cell_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [7:0]  dev_r;
  logic [7:0]  tmo_r;
  logic        ready;
  logic        expired;
  logic [4:0]  cnt_inc;

  assign ready   = (step_r == ST_READY);
  assign expired = (wait_r > tmo_r) || (wait_r == 8'hFF);
  assign cnt_inc = cnt_r + 5'd1;
  assign rd_addr = cnt_nxt[BUF_AW-1:0];

  always_comb begin
    step_nxt = step_r;
    ret_nxt  = ret_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    mode_nxt = mode_r;
    cell_nxt = cell_r;
    ok_nxt   = ok_r;
    wait_nxt = wait_r;
    wr       = '0;
    res      = '0;
    if (item_acc) begin
      case (item.opcode)
        OP_TICK: begin
          case (step_r)
            ST_READY: begin
            end
            ST_START: begin
              res.bus_action = ACT_START;
              ret_nxt  = ST_DEV;
              step_nxt = ST_WAIT_BIT;
              cnt_nxt  = '0;
            end
            ST_DEV: begin
              res.bus_action = ACT_SEND;
              res.tx_byte    = dev_r;
              ret_nxt  = ST_CELL_HI;
              step_nxt = ST_WAIT_BYTE;
            end
            ST_CELL_HI: begin
              res.bus_action = ACT_SEND;
              res.tx_byte    = cell_r[15:8];
              ret_nxt  = ST_CELL_LO;
              step_nxt = ST_WAIT_BYTE;
            end
            ST_CELL_LO: begin
              res.bus_action = ACT_SEND;
              res.tx_byte    = cell_r[7:0];
              if (mode_r) begin
                ret_nxt  = ST_DATA;
                step_nxt = ST_WAIT_BYTE;
              end else begin
                ret_nxt  = ST_RESTART;
                step_nxt = ST_WAIT_BIT;
              end
            end
            ST_DATA: begin
              if (cnt_r != len_r) begin
                res.bus_action = ACT_SEND;
                res.tx_byte    = rd_data;
                cnt_nxt  = cnt_inc;
                step_nxt = ST_WAIT_BYTE;
              end else begin
                ok_nxt   = 1'b1;
                step_nxt = ST_STOP;
              end
            end
            ST_RESTART: begin
              res.bus_action = ACT_RESTART;
              ret_nxt  = ST_DEV_READ;
              step_nxt = ST_WAIT_BIT;
            end
            ST_DEV_READ: begin
              res.bus_action = ACT_SEND;
              res.tx_byte    = dev_r | 8'h01;
              cnt_nxt  = '0;
              ret_nxt  = ST_RCV_EN;
              step_nxt = ST_WAIT_BYTE;
            end
            ST_RCV_EN: begin
              res.bus_action = ACT_RCV_EN;
              ret_nxt  = ST_IN_DATA;
              step_nxt = ST_WAIT_BIT;
            end
            ST_IN_DATA: begin
              if (item.receive_full) begin
                cnt_nxt        = cnt_inc;
                res.read_valid = 1'b1;
                res.read_byte  = item.receive_byte;
                res.bus_action = ACT_ACK;
                if (cnt_inc == len_r) begin
                  res.ack_bit = 1'b1;
                  ok_nxt      = 1'b1;
                  ret_nxt     = ST_STOP;
                end else begin
                  ret_nxt = ST_RCV_EN;
                end
                step_nxt = ST_WAIT_BIT;
              end
            end
            ST_WAIT_BIT: begin
              if (item.bus_event) begin
                step_nxt = ret_r;
                wait_nxt = '0;
              end else if (expired) begin
                res.bus_action = ACT_STOP;
                step_nxt = ST_READY;
                ok_nxt   = 1'b0;
                wait_nxt = '0;
              end else begin
                wait_nxt = wait_r + 8'd1;
              end
            end
            ST_WAIT_BYTE: begin
              if (item.bus_event) begin
                if (!item.ack_status) begin
                  step_nxt = ret_r;
                end else begin
                  step_nxt = ST_STOP;
                  ok_nxt   = 1'b0;
                end
                wait_nxt = '0;
              end else if (expired) begin
                step_nxt = ST_STOP;
                ok_nxt   = 1'b0;
                wait_nxt = '0;
              end else begin
                wait_nxt = wait_r + 8'd1;
              end
            end
            ST_STOP: begin
              res.bus_action = ACT_STOP;
              ret_nxt  = ST_READY;
              step_nxt = ST_WAIT_BIT;
            end
            default: begin
              step_nxt = ST_READY;
            end
          endcase
        end
        OP_LOAD: begin
          if (ready && ({1'b0, item.byte_index} < 5'(BUFFER_DEPTH))) begin
            wr.en        = 1'b1;
            wr.addr      = item.byte_index[BUF_AW-1:0];
            wr.data      = item.byte_value;
            res.accepted = 1'b1;
          end
        end
        OP_START: begin
          if (ready && (32'(item.transfer_length) <= BUFFER_DEPTH) &&
              !(!item.write_mode && (item.transfer_length == 5'd0))) begin
            mode_nxt     = item.write_mode;
            cell_nxt     = item.cell_address;
            len_nxt      = item.transfer_length;
            step_nxt     = ST_START;
            res.accepted = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.idle    = (step_nxt == ST_READY);
      res.success = ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_READY;
      ret_r  <= ST_READY;
      cnt_r  <= '0;
      ok_r   <= 1'b0;
      wait_r <= '0;
    end else begin
      step_r <= step_nxt;
      ret_r  <= ret_nxt;
      cnt_r  <= cnt_nxt;
      ok_r   <= ok_nxt;
      wait_r <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    mode_r <= mode_nxt;
    cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= 8'd0;
      tmo_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_r <= cfg_wdata;
        CFG_TIMEOUT_LIMIT:  tmo_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  `IETS_ASSERT_NEXT(a_load_stays_ready, item_acc && (item.opcode == OP_LOAD) && res.accepted, step_r == ST_READY, "load left ready state")
  `IETS_ASSERT_SAME(a_read_acks, item_acc && res.read_valid, res.bus_action == ACT_ACK, "read byte without ack action")
  `IETS_ASSERT_SAME(a_data_count, step_r == ST_DATA, cnt_r <= len_r, "write count passed length")
  `IETS_ASSERT_SAME(a_ready_wait_clear, step_r == ST_READY, wait_r == 8'd0, "wait count live in ready")

endmodule

// ===== src/iets_oq.sv =====
// Result output register with a skid stage behind valid/stall.
// Depends on iets_pkg for the result word type and on the assertion macro header.
`include "i2c_eeprom_transaction_sequencer_defines.svh"
module iets_oq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_acc,
  input  iets_pkg::res_t in_res,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output iets_pkg::res_t out_res
);
  import iets_pkg::*;

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_data_r;
  res_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
      if (out_valid_r && out_stall) begin
        skid_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && out_stall) begin
        skid_data_r <= in_res;
      end else begin
        out_data_r <= in_res;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  `IETS_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds word with empty output")
  `IETS_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_r), $past(out_stall), "skid filled without stall")
  `IETS_ASSERT_NEXT(a_drain, out_valid_r && !out_stall && !skid_valid_r && !in_acc, !out_valid_r, "taken word not dropped")

endmodule

// ===== src/i2c_eeprom_transaction_sequencer.sv =====
// Top level of the I2C EEPROM transaction sequencer.
// Depends on iets_pkg, iets_buf, iets_ctrl and iets_oq.
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid / in_stall  opcode, mode, address, length, load, bus flags
//   out_*     output     out_valid/out_stall  bus action, tx byte, ack, read byte, status
//   cfg_*     input      cfg_we               cfg_index, cfg_wdata (8 bits)
//
// One input word is taken every cycle while in_stall is low; its result word is
// registered in the output or skid register. The write buffer is a 16-entry memory with a
// registered read; its read address tracks the next byte count so the byte to
// send is ready when the data step runs. Reset (synchronous, rst_n low) puts the
// sequencer in ready with zeroed counters; buffer contents are left as they are.
// A stall on out fills a one-word skid stage; in_stall rises only while it is full.
module i2c_eeprom_transaction_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_write_mode,
  input  logic [15:0] in_cell_address,
  input  logic [4:0]  in_transfer_length,
  input  logic [3:0]  in_byte_index,
  input  logic [7:0]  in_byte_value,
  input  logic        in_bus_event,
  input  logic        in_ack_status,
  input  logic        in_receive_full,
  input  logic [7:0]  in_receive_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_bus_action,
  output logic [7:0]  out_tx_byte,
  output logic        out_ack_bit,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_accepted,
  output logic        out_idle,
  output logic        out_success
);
  import iets_pkg::*;

  item_t             item;
  res_t              res;
  res_t              out_res;
  buf_wr_t           wr;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              item_acc;
  logic              oq_full;

  // take a word whenever the skid stage has room
  assign in_stall = oq_full;
  assign item_acc = in_valid && !oq_full;

  assign item.opcode          = in_opcode;
  assign item.write_mode      = in_write_mode;
  assign item.cell_address    = in_cell_address;
  assign item.transfer_length = in_transfer_length;
  assign item.byte_index      = in_byte_index;
  assign item.byte_value      = in_byte_value;
  assign item.bus_event       = in_bus_event;
  assign item.ack_status      = in_ack_status;
  assign item.receive_full    = in_receive_full;
  assign item.receive_byte    = in_receive_byte;

  iets_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  iets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_acc  (item_acc),
    .item      (item),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .res       (res)
  );

  iets_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (item_acc),
    .in_res    (res),
    .full      (oq_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_bus_action = out_res.bus_action;
  assign out_tx_byte    = out_res.tx_byte;
  assign out_ack_bit    = out_res.ack_bit;
  assign out_read_valid = out_res.read_valid;
  assign out_read_byte  = out_res.read_byte;
  assign out_accepted   = out_res.accepted;
  assign out_idle       = out_res.idle;
  assign out_success    = out_res.success;

endmodule
